[src/aspd_pkg.sv]
// ----------------------------------------------------------------------------
// aspd_pkg
// Shared types, widths and constants for the aligned sequence pair distance
// block: reason codes, register indexes, controller states and command bus.
// ----------------------------------------------------------------------------
package aspd_pkg;

  localparam int MAX_COLUMNS   = 4096;
  localparam int ALPHABET_SIZE = 20;

  localparam int CharW    = 8;
  localparam int CntW     = 13;
  localparam int DistW    = 17;
  localparam int ReasonW  = 3;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 17;
  localparam int SlotW    = $clog2(ALPHABET_SIZE);
  localparam int DiffW    = CntW + SlotW;
  localparam int StepW    = $clog2(DistW);

  localparam logic [CntW-1:0]  COUNT_MAX    = '1;
  localparam logic [DistW-1:0] ONE_Q16      = 17'h10000;
  localparam logic [CharW-1:0] LETTER_FIRST = 8'h41;
  localparam logic [CharW-1:0] LETTER_END   = LETTER_FIRST + CharW'(ALPHABET_SIZE);

  localparam logic [CntW-1:0]  MIN_COMP_RST = 13'd10;
  localparam logic [DistW-1:0] SIMILAR_RST  = 17'd6553;

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CFG_MIN_COMP = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SIMILAR  = 2'd1;

  typedef enum logic [ReasonW-1:0] {
    RSN_COMPUTED   = 3'd0,
    RSN_EMPTY      = 3'd1,
    RSN_SIMILAR    = 3'd2,
    RSN_NO_OVERLAP = 3'd3,
    RSN_FEW        = 3'd4
  } reason_e;

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_REDUCE,
    ST_DECIDE,
    ST_DIVIDE,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic take;
    logic reduce_step;
    logic decide;
    logic div_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic reduce_last;
    logic need_div;
    logic div_last;
  } status_t;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    return (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

endpackage

[src/aspd_if.sv]
// ----------------------------------------------------------------------------
// aspd interfaces
// Valid/ready channels for alignment columns, distance results and
// configuration writes.
// ----------------------------------------------------------------------------
interface aspd_col_if;
  import aspd_pkg::*;
  logic             valid;
  logic             ready;
  logic [CharW-1:0] residue_a;
  logic [CharW-1:0] residue_b;
  logic             column_last;
  modport source(output valid, residue_a, residue_b, column_last, input ready);
  modport sink(input valid, residue_a, residue_b, column_last, output ready);
endinterface

interface aspd_res_if;
  import aspd_pkg::*;
  logic               valid;
  logic               ready;
  logic [DistW-1:0]   distance_q16;
  logic [ReasonW-1:0] reason;
  logic [CntW-1:0]    match_count;
  logic [CntW-1:0]    compare_count;
  modport source(output valid, distance_q16, reason, match_count, compare_count,
                 input ready);
  modport sink(input valid, distance_q16, reason, match_count, compare_count,
               output ready);
endinterface

interface aspd_cfg_if;
  import aspd_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

[src/aspd_ctrl.sv]
// ----------------------------------------------------------------------------
// aspd_ctrl
// Controller: column intake, letter reduction, decision, division and the
// result handshake.
// ----------------------------------------------------------------------------
module aspd_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               col_valid_i,
  input  logic               col_last_i,
  output logic               col_ready_o,
  input  logic               res_ready_i,
  output logic               res_valid_o,
  input  aspd_pkg::status_t  status_i,
  output aspd_pkg::cmd_t     cmd_o
);
  import aspd_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACCUM;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    col_ready_o = 1'b0;
    case (state_q)
      ST_ACCUM: begin
        col_ready_o = 1'b1;
        if (col_valid_i) begin
          cmd_o.take = 1'b1;
          if (col_last_i) state_d = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        cmd_o.reduce_step = 1'b1;
        if (status_i.reduce_last) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d = status_i.need_div ? ST_DIVIDE : ST_EMIT;
      end
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        // output register free or being drained this cycle
        if (!out_valid_q || res_ready_i) begin
          cmd_o.emit = 1'b1;
          state_d = ST_ACCUM;
        end
      end
      default: state_d = ST_ACCUM;
    endcase
    out_valid_d = cmd_o.emit | (out_valid_q & ~res_ready_i);
  end

  assign res_valid_o = out_valid_q;

endmodule

[src/aspd_datapath.sv]
// ----------------------------------------------------------------------------
// aspd_datapath
// Per-pair counters, letter composition reduction, decision logic, a
// restoring divider for the Q16 p-distance, and the result register.
// ----------------------------------------------------------------------------
module aspd_datapath #(
  parameter int MaxColumns = aspd_pkg::MAX_COLUMNS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  aspd_pkg::cmd_t                cmd_i,
  output aspd_pkg::status_t             status_o,
  input  logic [aspd_pkg::CharW-1:0]    residue_a_i,
  input  logic [aspd_pkg::CharW-1:0]    residue_b_i,
  input  logic                          cfg_we_i,
  input  logic [aspd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [aspd_pkg::CfgDataW-1:0] cfg_data_i,
  output logic [aspd_pkg::DistW-1:0]    distance_q16_o,
  output logic [aspd_pkg::ReasonW-1:0]  reason_o,
  output logic [aspd_pkg::CntW-1:0]     match_count_o,
  output logic [aspd_pkg::CntW-1:0]     compare_count_o
);
  import aspd_pkg::*;

  localparam int ColW = $clog2(MaxColumns);
  localparam logic [ColW-1:0] ColLast = ColW'(MaxColumns - 1);
  localparam int ScW = DiffW + 4;

  logic [CntW-1:0]  cnt_a_q [ALPHABET_SIZE];
  logic [CntW-1:0]  cnt_b_q [ALPHABET_SIZE];
  logic [CntW-1:0]  res_a_q, res_b_q, match_q, comp_q;
  logic [ColW-1:0]  first_a_q, last_a_q, first_b_q, last_b_q, col_q;
  logic [CntW-1:0]  min_comp_q;
  logic [DistW-1:0] similar_q;
  logic [SlotW-1:0] red_idx_q;
  logic [DiffW-1:0] diff_q;
  logic [StepW-1:0] step_q;

  logic [DistW-1:0] dist_q;
  reason_e          reason_q;
  logic [CntW:0]    rem_q;
  logic [DistW-1:0] quot_q;

  logic [DistW-1:0] out_dist_q;
  reason_e          out_reason_q;
  logic [CntW-1:0]  out_match_q, out_comp_q;

  logic             is_a, is_b, take_a, take_b;
  logic [SlotW-1:0] slot_a, slot_b;
  logic [CntW-1:0]  cur_a, cur_b, abs_diff, miss;
  logic [ScW-1:0]   scaled;
  logic [CntW:0]    res_sum, div_rem;
  logic [ColW-1:0]  lo_col, hi_col;
  logic             div_ge;
  reason_e          dec_reason;
  logic [DistW-1:0] dec_dist;

  // column classification
  assign is_a   = (residue_a_i >= LETTER_FIRST) && (residue_a_i < LETTER_END);
  assign is_b   = (residue_b_i >= LETTER_FIRST) && (residue_b_i < LETTER_END);
  assign slot_a = SlotW'(residue_a_i - LETTER_FIRST);
  assign slot_b = SlotW'(residue_b_i - LETTER_FIRST);
  assign take_a = cmd_i.take && is_a;
  assign take_b = cmd_i.take && is_b;

  // one letter per reduction step
  assign cur_a    = cnt_a_q[red_idx_q];
  assign cur_b    = cnt_b_q[red_idx_q];
  assign abs_diff = (cur_a > cur_b) ? cur_a - cur_b : cur_b - cur_a;

  assign scaled  = (ScW'(diff_q) << 3) + (ScW'(diff_q) << 1);
  assign res_sum = {1'b0, res_a_q} + {1'b0, res_b_q};
  assign lo_col  = (first_a_q > first_b_q) ? first_a_q : first_b_q;
  assign hi_col  = (last_a_q < last_b_q) ? last_a_q : last_b_q;
  assign miss    = (comp_q > match_q) ? comp_q - match_q : '0;

  always_comb begin
    dec_reason = RSN_COMPUTED;
    dec_dist   = ONE_Q16;
    if (res_a_q == '0 || res_b_q == '0) begin
      dec_reason = RSN_EMPTY;
    end else if (scaled < ScW'(res_sum)) begin
      dec_reason = RSN_SIMILAR;
      dec_dist   = similar_q;
    end else if (lo_col > hi_col) begin
      dec_reason = RSN_NO_OVERLAP;
    end else if (comp_q < min_comp_q || comp_q == '0) begin
      dec_reason = RSN_FEW;
    end
  end

  // restoring divider, one quotient bit per step, msb first
  assign div_ge  = rem_q >= {1'b0, comp_q};
  assign div_rem = div_ge ? rem_q - {1'b0, comp_q} : rem_q;

  assign status_o.reduce_last = (red_idx_q == SlotW'(ALPHABET_SIZE - 1));
  assign status_o.need_div    = (dec_reason == RSN_COMPUTED);
  assign status_o.div_last    = (step_q == StepW'(DistW - 1));

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_comp_q <= MIN_COMP_RST;
      similar_q  <= SIMILAR_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_MIN_COMP) min_comp_q <= cfg_data_i[CntW-1:0];
      if (cfg_index_i == CFG_SIMILAR)  similar_q  <= cfg_data_i[DistW-1:0];
    end
  end

  // pair accumulation
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ALPHABET_SIZE; i++) begin
        cnt_a_q[i] <= '0;
        cnt_b_q[i] <= '0;
      end
      res_a_q   <= '0;
      res_b_q   <= '0;
      match_q   <= '0;
      comp_q    <= '0;
      first_a_q <= '0;
      last_a_q  <= '0;
      first_b_q <= '0;
      last_b_q  <= '0;
      col_q     <= '0;
      red_idx_q <= '0;
      diff_q    <= '0;
      step_q    <= '0;
    end else if (cmd_i.emit) begin
      for (int i = 0; i < ALPHABET_SIZE; i++) begin
        cnt_a_q[i] <= '0;
        cnt_b_q[i] <= '0;
      end
      res_a_q   <= '0;
      res_b_q   <= '0;
      match_q   <= '0;
      comp_q    <= '0;
      first_a_q <= '0;
      last_a_q  <= '0;
      first_b_q <= '0;
      last_b_q  <= '0;
      col_q     <= '0;
      red_idx_q <= '0;
      diff_q    <= '0;
    end else begin
      if (take_a) begin
        if (res_a_q == '0) first_a_q <= col_q;
        last_a_q <= col_q;
        res_a_q  <= sat_inc(res_a_q);
      end
      if (take_b) begin
        if (res_b_q == '0) first_b_q <= col_q;
        last_b_q <= col_q;
        res_b_q  <= sat_inc(res_b_q);
      end
      for (int i = 0; i < ALPHABET_SIZE; i++) begin
        if (take_a && slot_a == SlotW'(i)) cnt_a_q[i] <= sat_inc(cnt_a_q[i]);
        if (take_b && slot_b == SlotW'(i)) cnt_b_q[i] <= sat_inc(cnt_b_q[i]);
      end
      if (take_a && take_b) begin
        comp_q <= sat_inc(comp_q);
        if (slot_a == slot_b) match_q <= sat_inc(match_q);
      end
      if (cmd_i.take && col_q != ColLast) col_q <= col_q + 1'b1;
      if (cmd_i.reduce_step) begin
        diff_q    <= diff_q + DiffW'(abs_diff);
        red_idx_q <= red_idx_q + 1'b1;
      end
      if (cmd_i.decide)   step_q <= '0;
      if (cmd_i.div_step) step_q <= step_q + 1'b1;
    end
  end

  // decision, divider and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      dist_q   <= dec_dist;
      reason_q <= dec_reason;
      rem_q    <= {1'b0, miss};
      quot_q   <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q  <= {div_rem[CntW-1:0], 1'b0};
      quot_q <= {quot_q[DistW-2:0], div_ge};
    end
    if (cmd_i.emit) begin
      out_dist_q   <= (reason_q == RSN_COMPUTED) ? quot_q : dist_q;
      out_reason_q <= reason_q;
      out_match_q  <= match_q;
      out_comp_q   <= comp_q;
    end
  end

  assign distance_q16_o  = out_dist_q;
  assign reason_o        = out_reason_q;
  assign match_count_o   = out_match_q;
  assign compare_count_o = out_comp_q;

endmodule

[src/aligned_sequence_pair_distance.sv]
// ----------------------------------------------------------------------------
// aligned_sequence_pair_distance
// Q16 p-distance of two aligned sequences with a composition pre-filter.
// ----------------------------------------------------------------------------
// Columns are taken one per cycle until the last column of a pair.
// After the last column the block sweeps the composition of all 20 letters,
// takes the decision, runs a 17-step restoring divider for a computed
// distance only, and loads the result register once it is free or draining.
// Reset clears all pair counters and loads min_comparisons = 10 and
// similar_distance_q16 = 6553; the configuration port is always ready.
module aligned_sequence_pair_distance #(
  parameter int MaxColumns = aspd_pkg::MAX_COLUMNS
) (
  input logic       clk_i,
  input logic       rst_ni,
  aspd_col_if.sink   col_i,
  aspd_res_if.source res_o,
  aspd_cfg_if.sink   cfg_i
);
  import aspd_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_i.ready = 1'b1;

  aspd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .col_valid_i (col_i.valid),
    .col_last_i  (col_i.column_last),
    .col_ready_o (col_i.ready),
    .res_ready_i (res_o.ready),
    .res_valid_o (res_o.valid),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  aspd_datapath #(
    .MaxColumns (MaxColumns)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .residue_a_i     (col_i.residue_a),
    .residue_b_i     (col_i.residue_b),
    .cfg_we_i        (cfg_i.valid & cfg_i.ready),
    .cfg_index_i     (cfg_i.index),
    .cfg_data_i      (cfg_i.data),
    .distance_q16_o  (res_o.distance_q16),
    .reason_o        (res_o.reason),
    .match_count_o   (res_o.match_count),
    .compare_count_o (res_o.compare_count)
  );

`ifndef ASSERT_OFF
  a_computed_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.reason == RSN_COMPUTED |-> res_o.distance_q16 <= ONE_Q16)
    else $error("computed distance above 1.0");

  a_match_le_compare: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> res_o.match_count <= res_o.compare_count)
    else $error("more matches than comparisons");

  a_fixed_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (res_o.reason == RSN_EMPTY || res_o.reason == RSN_NO_OVERLAP ||
                    res_o.reason == RSN_FEW) |-> res_o.distance_q16 == ONE_Q16)
    else $error("fallback reason without distance 1.0");

  a_no_intake_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_i.valid && col_i.ready && col_i.column_last |=> !col_i.ready)
    else $error("column taken during pair reduction");
`endif

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Streams alignment column pairs into aligned_sequence_pair_distance under
// random source and sink stalls. A scoreboard tracks letter counts, overlap
// and comparisons per pair, and checks every distance result field by field.
// ----------------------------------------------------------------------------
import aspd_pkg::*;

localparam int unsigned PosW             = 12;
localparam int unsigned CompositionScale = 10;

typedef struct packed {
  logic [DistW-1:0] distance_q16;
  reason_e          reason;
  logic [CntW-1:0]  match_count;
  logic [CntW-1:0]  compare_count;
} pair_result_t;

class distance_scoreboard;
  logic [CntW-1:0]  min_comparisons;
  logic [DistW-1:0] similar_q16;
  logic [CntW-1:0]  letters_a[ALPHABET_SIZE];
  logic [CntW-1:0]  letters_b[ALPHABET_SIZE];
  logic [CntW-1:0]  residues_a, residues_b, equal_count, comparisons, column;
  logic [PosW-1:0]  first_a, last_a, first_b, last_b;
  pair_result_t     distance_q[$];
  int unsigned      errors;

  function new();
    min_comparisons = MIN_COMP_RST;
    similar_q16     = SIMILAR_RST;
    errors          = 0;
    clear_pair();
  endfunction

  function void clear_pair();
    foreach (letters_a[i]) begin
      letters_a[i] = '0;
      letters_b[i] = '0;
    end
    residues_a  = '0;
    residues_b  = '0;
    equal_count = '0;
    comparisons = '0;
    column      = '0;
    first_a     = '0;
    last_a      = '0;
    first_b     = '0;
    last_b      = '0;
  endfunction

  function logic [CntW-1:0] bump(logic [CntW-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function int unsigned pending();
    return distance_q.size();
  endfunction

  function void write_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    case (idx)
      CFG_MIN_COMP: min_comparisons = data[CntW-1:0];
      CFG_SIMILAR:  similar_q16 = data;
      default: ;
    endcase
  endfunction

  function void note_column(logic [CharW-1:0] ch_a, logic [CharW-1:0] ch_b, logic last);
    logic             is_a, is_b;
    logic [SlotW-1:0] slot_a, slot_b;
    logic [PosW-1:0]  pos, lo, hi;
    int unsigned      diff;
    pair_result_t     want;
    is_a   = (ch_a >= LETTER_FIRST) && (ch_a < LETTER_END);
    is_b   = (ch_b >= LETTER_FIRST) && (ch_b < LETTER_END);
    slot_a = SlotW'(ch_a - LETTER_FIRST);
    slot_b = SlotW'(ch_b - LETTER_FIRST);
    pos    = column[PosW-1:0];
    if (is_a) begin
      if (residues_a == '0) first_a = pos;
      last_a            = pos;
      residues_a        = bump(residues_a);
      letters_a[slot_a] = bump(letters_a[slot_a]);
    end
    if (is_b) begin
      if (residues_b == '0) first_b = pos;
      last_b            = pos;
      residues_b        = bump(residues_b);
      letters_b[slot_b] = bump(letters_b[slot_b]);
    end
    if (is_a && is_b) begin
      comparisons = bump(comparisons);
      if (slot_a == slot_b) equal_count = bump(equal_count);
    end
    // position sticks at the last column slot on long pairs
    if (column < CntW'(MAX_COLUMNS - 1)) column = column + 1'b1;
    if (!last) return;

    diff = 0;
    for (int i = 0; i < ALPHABET_SIZE; i++) begin
      diff += (letters_a[i] > letters_b[i]) ? 32'(letters_a[i] - letters_b[i])
                                            : 32'(letters_b[i] - letters_a[i]);
    end
    lo = (first_a > first_b) ? first_a : first_b;
    hi = (last_a < last_b) ? last_a : last_b;

    want.match_count   = equal_count;
    want.compare_count = comparisons;
    if (residues_a == '0 || residues_b == '0) begin
      want.distance_q16 = ONE_Q16;
      want.reason       = RSN_EMPTY;
    end else if (CompositionScale * diff < 32'(residues_a) + 32'(residues_b)) begin
      want.distance_q16 = similar_q16;
      want.reason       = RSN_SIMILAR;
    end else if (lo > hi) begin
      want.distance_q16 = ONE_Q16;
      want.reason       = RSN_NO_OVERLAP;
    end else if (comparisons < min_comparisons || comparisons == '0) begin
      want.distance_q16 = ONE_Q16;
      want.reason       = RSN_FEW;
    end else begin
      want.distance_q16 = DistW'((32'(comparisons - equal_count) * 32'(ONE_Q16))
                                 / 32'(comparisons));
      want.reason       = RSN_COMPUTED;
    end
    distance_q = {distance_q, want};
    clear_pair();
  endfunction

  function void check_result(pair_result_t got);
    pair_result_t want;
    if (distance_q.size() == 0) begin
      $error("distance result with no pair outstanding: distance_q16 %0d reason %0d",
             got.distance_q16, got.reason);
      errors++;
      return;
    end
    want = distance_q.pop_front();
    if (got.distance_q16 !== want.distance_q16) begin
      $error("distance_q16 mismatch: expected %0d, actual %0d",
             want.distance_q16, got.distance_q16);
      errors++;
    end
    if (got.reason !== want.reason) begin
      $error("reason mismatch: expected %0d, actual %0d", want.reason, got.reason);
      errors++;
    end
    if (got.match_count !== want.match_count) begin
      $error("match_count mismatch: expected %0d, actual %0d",
             want.match_count, got.match_count);
      errors++;
    end
    if (got.compare_count !== want.compare_count) begin
      $error("compare_count mismatch: expected %0d, actual %0d",
             want.compare_count, got.compare_count);
      errors++;
    end
  endfunction
endclass

module testbench;
  localparam int          RunLimit        = 10_000_000;
  localparam int unsigned SettleCycles    = 60;
  localparam int unsigned PhaseItems      = 190;
  localparam int unsigned LongPairColumns = 170;

  // indexes with no register behind them
  localparam logic [CfgIdxW-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_B = 2'd3;

  localparam logic [CharW-1:0] GAP_DASH = "-";

  typedef enum int {
    PAIR_RELATED,
    PAIR_INDEPENDENT,
    PAIR_SPLIT,
    PAIR_ONE_SIDED,
    PAIR_NOISE
  } pair_kind_e;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic source_fast;
  int unsigned phase_items;
  distance_scoreboard board;

  aspd_col_if col_bus ();
  aspd_res_if res_bus ();
  aspd_cfg_if cfg_bus ();

  aligned_sequence_pair_distance dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .col_i (col_bus),
    .res_o (res_bus),
    .cfg_i (cfg_bus)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [CharW-1:0] letter_from(int unsigned base, int unsigned count);
    return LETTER_FIRST + CharW'(base + $urandom_range(0, count - 1));
  endfunction

  function automatic logic [CharW-1:0] any_gap();
    logic [CharW-1:0] ch;
    case ($urandom_range(0, 3))
      0: ch = GAP_DASH;
      1: ch = LETTER_END + CharW'($urandom_range(0, 5));
      default: begin
        do ch = CharW'($urandom_range(0, 255));
        while (ch >= LETTER_FIRST && ch < LETTER_END);
      end
    endcase
    return ch;
  endfunction

  function automatic logic [CharW-1:0] letter_or_gap(int unsigned gap_pct);
    return ($urandom_range(0, 99) < gap_pct) ? any_gap() : letter_from(0, ALPHABET_SIZE);
  endfunction

  task automatic send_column(input logic [CharW-1:0] ch_a, input logic [CharW-1:0] ch_b,
                             input logic last);
    int unsigned gap;
    gap = source_fast ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      col_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    col_bus.valid       <= 1'b1;
    col_bus.residue_a   <= ch_a;
    col_bus.residue_b   <= ch_b;
    col_bus.column_last <= last;
    do @(posedge clk_i); while (!col_bus.ready);
    board.note_column(ch_a, ch_b, last);
    phase_items++;
  endtask

  task automatic send_pair(input pair_kind_e kind, input int unsigned len);
    logic [CharW-1:0] ch_a, ch_b, swap;
    int unsigned      gap_pct, mut_pct, cut;
    logic             b_side;
    gap_pct     = $urandom_range(0, 30);
    mut_pct     = $urandom_range(0, 60);
    cut         = $urandom_range(1, (len > 1) ? len - 1 : 1);
    b_side      = 1'($urandom_range(0, 1));
    source_fast = ($urandom_range(0, 3) == 0);
    for (int unsigned i = 0; i < len; i++) begin
      case (kind)
        PAIR_RELATED: begin
          // b follows a with occasional substitutions, so compositions stay close
          ch_a = letter_or_gap(gap_pct);
          if ($urandom_range(0, 99) < mut_pct) ch_b = letter_or_gap(50);
          else ch_b = ch_a;
        end
        PAIR_INDEPENDENT: begin
          ch_a = letter_or_gap(gap_pct);
          ch_b = letter_or_gap(gap_pct);
        end
        PAIR_SPLIT: begin
          // a lives before the cut, b after it, on disjoint letter sets
          ch_a = (i < cut && $urandom_range(0, 99) >= gap_pct) ? letter_from(0, 10)
                                                              : any_gap();
          ch_b = (i >= cut && $urandom_range(0, 99) >= gap_pct) ? letter_from(10, 10)
                                                               : any_gap();
        end
        PAIR_ONE_SIDED: begin
          ch_a = letter_or_gap(gap_pct);
          ch_b = any_gap();
          if (b_side) begin
            swap = ch_a;
            ch_a = ch_b;
            ch_b = swap;
          end
        end
        default: begin
          ch_a = CharW'($urandom_range(0, 255));
          ch_b = CharW'($urandom_range(0, 255));
        end
      endcase
      send_column(ch_a, ch_b, i == len - 1);
    end
  endtask

  task automatic run_random_pairs(input int unsigned count);
    pair_kind_e  kind;
    int unsigned pick, len;
    phase_items = 0;
    while (phase_items < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) kind = PAIR_RELATED;
      else if (pick < 65) kind = PAIR_INDEPENDENT;
      else if (pick < 77) kind = PAIR_SPLIT;
      else if (pick < 85) kind = PAIR_ONE_SIDED;
      else kind = PAIR_NOISE;
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 24);
      send_pair(kind, len);
    end
  endtask

  task automatic wait_idle();
    col_bus.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic put_register(input logic [CfgIdxW-1:0] idx,
                              input logic [CfgDataW-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk_i); while (!cfg_bus.ready);
    board.write_register(idx, data);
  endtask

  task automatic reconfigure(input logic [CfgDataW-1:0] min_comp,
                             input logic [CfgDataW-1:0] similar, input logic spare);
    wait_idle();
    put_register(CFG_MIN_COMP, min_comp);
    if (spare) begin
      put_register(CFG_SPARE_A, CfgDataW'($urandom()));
      put_register(CFG_SPARE_B, CfgDataW'($urandom()));
    end
    put_register(CFG_SIMILAR, similar);
    cfg_bus.valid <= 1'b0;
  endtask

  initial begin : result_sink
    int unsigned  stall;
    logic         fast;
    pair_result_t got;
    fast = 1'b0;
    res_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      // flip between stretches of full rate and random stalls
      if ($urandom_range(0, 15) == 0) fast = !fast;
      stall = fast ? 0 : $urandom_range(0, 8);
      if (stall != 0) begin
        res_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_bus.ready <= 1'b1;
      do @(posedge clk_i); while (res_bus.valid !== 1'b1);
      got.distance_q16  = res_bus.distance_q16;
      got.reason        = reason_e'(res_bus.reason);
      got.match_count   = res_bus.match_count;
      got.compare_count = res_bus.compare_count;
      board.check_result(got);
    end
  end

  initial begin
    board = new();
    source_fast = 1'b0;
    phase_items = 0;
    rst_ni              <= 1'b0;
    col_bus.valid       <= 1'b0;
    col_bus.residue_a   <= '0;
    col_bus.residue_b   <= '0;
    col_bus.column_last <= 1'b0;
    cfg_bus.valid       <= 1'b0;
    cfg_bus.index       <= CFG_MIN_COMP;
    cfg_bus.data        <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: single columns, letter range edges, each decision path
    send_column("A", "A", 1'b1);
    send_column(8'h00, "T", 1'b1);
    send_column("@", "U", 1'b0);
    send_column(8'hff, 8'h80, 1'b0);
    send_column("T", "T", 1'b1);
    send_column("A", "-", 1'b0);
    send_column("-", "B", 1'b1);
    send_column("A", "B", 1'b0);
    send_column("C", "D", 1'b1);
    for (int i = 0; i < 10; i++) begin
      send_column(LETTER_FIRST + CharW'(i), (i == 0) ? "A" : LETTER_FIRST + CharW'(10 + i),
                  i == 9);
    end

    // overlapping residues but no both-residue column
    reconfigure('0, '0, 1'b1);
    send_column("A", "-", 1'b0);
    send_column("-", "B", 1'b0);
    send_column("C", "-", 1'b1);
    run_random_pairs(PhaseItems);

    // longer pair against a comparison floor it cannot reach
    reconfigure(CfgDataW'(MAX_COLUMNS), ONE_Q16, 1'b0);
    source_fast = ($urandom_range(0, 1) == 0);
    for (int i = 0; i < LongPairColumns; i++) begin
      send_column("A", (i < 50) ? GAP_DASH : (i % 16 == 0) ? "A" : letter_from(1, 19),
                  i == LongPairColumns - 1);
    end
    run_random_pairs(PhaseItems);

    reconfigure('1, '1, 1'b0);
    run_random_pairs(PhaseItems);

    reconfigure(CfgDataW'(1), CfgDataW'(1), 1'b0);
    run_random_pairs(PhaseItems);

    for (int p = 0; p < 4; p++) begin
      reconfigure(CfgDataW'($urandom_range(0, 40)), CfgDataW'($urandom_range(0, 65536)),
                  1'b0);
      run_random_pairs(PhaseItems);
    end

    wait_idle();
    if (board.errors == 0 && board.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #(RunLimit);
    $display("tb: failure");
    $finish;
  end
endmodule
